// ----- rtl/ipcl2_pkg.sv -----
// ----------------------------------------------------------------------------
// IP classifier L2 prefetcher package
// Shared constants, controller states and the command and status types that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package ipcl2_pkg;

  localparam int unsigned INDEX_BITS_DEF        = 6;
  localparam int unsigned TAG_BITS_DEF          = 9;
  localparam int unsigned BLOCK_OFFSET_BITS_DEF = 6;
  localparam int unsigned PAGE_OFFSET_BITS_DEF  = 12;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned META_W     = 13;
  localparam int unsigned LINE_OUT_W = 58;
  localparam int unsigned CLASS_W    = 4;
  localparam int unsigned STRIDE_W   = 7;
  localparam int unsigned DEG_W      = 3;

  localparam int unsigned META_CLASS_LSB = 8;
  localparam int unsigned META_NL_BIT    = 12;

  localparam logic [CLASS_W-1:0] CLASS_GLOBAL_STRIDE   = 4'd1;
  localparam logic [CLASS_W-1:0] CLASS_CONSTANT_STRIDE = 4'd2;
  localparam logic [CLASS_W-1:0] CLASS_NEXT_LINE       = 4'd4;

  localparam logic [DEG_W-1:0] DEGREE_MULTI = 3'd2;
  localparam logic [DEG_W-1:0] DEGREE_LOW   = 3'd3;
  localparam logic [DEG_W-1:0] DEGREE_HIGH  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PREP,
    ST_MISS,
    ST_STRIDE,
    ST_CLASS_NL
  } ctrl_state_e;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_MISS_NL,
    LD_STRIDE,
    LD_CLASS_NL
  } load_sel_e;

  typedef struct packed {
    logic      capture;
    logic      lookup;
    logic      prep;
    load_sel_e load;
  } dp_cmd_t;

  typedef struct packed {
    logic miss;
    logic stride_first;
    logic class_nl;
    logic stride_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/ipcl2_access_if.sv -----
// ----------------------------------------------------------------------------
// IP classifier L2 prefetcher access channel
// Valid and ready handshake carrying one cache access request.
// ----------------------------------------------------------------------------
interface ipcl2_access_if
  import ipcl2_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] access_address;
  logic [ADDR_W-1:0] instr_pointer;
  logic              is_prefetch;
  logic [META_W-1:0] metadata;
  logic              mshr_below_half;

  modport source (
    output valid, access_address, instr_pointer, is_prefetch, metadata, mshr_below_half,
    input  ready
  );

  modport sink (
    input  valid, access_address, instr_pointer, is_prefetch, metadata, mshr_below_half,
    output ready
  );
endinterface

// ----- rtl/ipcl2_prefetch_if.sv -----
// ----------------------------------------------------------------------------
// IP classifier L2 prefetcher prefetch channel
// Valid and ready handshake carrying one prefetch line address request.
// ----------------------------------------------------------------------------
interface ipcl2_prefetch_if
  import ipcl2_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [LINE_OUT_W-1:0] prefetch_line_address;
  logic                  last;

  modport source (
    output valid, prefetch_line_address, last,
    input  ready
  );

  modport sink (
    input  valid, prefetch_line_address, last,
    output ready
  );
endinterface

// ----- rtl/ipcl2_datapath.sv -----
// ----------------------------------------------------------------------------
// IP classifier L2 prefetcher datapath
// IP table memory, entry update, stride address generation, page check and
// the output register.
// ----------------------------------------------------------------------------
module ipcl2_datapath
  import ipcl2_pkg::*;
#(
  parameter int unsigned INDEX_BITS        = INDEX_BITS_DEF,
  parameter int unsigned TAG_BITS          = TAG_BITS_DEF,
  parameter int unsigned BLOCK_OFFSET_BITS = BLOCK_OFFSET_BITS_DEF,
  parameter int unsigned PAGE_OFFSET_BITS  = PAGE_OFFSET_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic [ADDR_W-1:0]     access_address_i,
  input  logic [ADDR_W-1:0]     instr_pointer_i,
  input  logic                  is_prefetch_i,
  input  logic [META_W-1:0]     metadata_i,
  input  logic                  mshr_below_half_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LINE_OUT_W-1:0] prefetch_line_address_o,
  output logic                  last_o
);

  localparam int unsigned DEPTH    = 1 << INDEX_BITS;
  localparam int unsigned LINE_W   = ADDR_W - BLOCK_OFFSET_BITS;
  localparam int unsigned PAGE_LSB = PAGE_OFFSET_BITS - BLOCK_OFFSET_BITS;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [CLASS_W-1:0]  cls;
    logic [STRIDE_W-1:0] stride;
  } entry_t;

  entry_t mem_q [DEPTH];
  entry_t rd_q;
  entry_t ent;
  entry_t upd;

  logic [DEPTH-1:0]      written_q;
  logic [DEPTH-1:0]      valid_q;
  logic                  multi_q;
  logic                  nle_q;

  logic [ADDR_W-1:0]     addr_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic                  is_pf_q;
  logic [META_W-1:0]     meta_q;
  logic                  below_q;

  logic [CLASS_W-1:0]    cls_q;
  logic [STRIDE_W-1:0]   s_q;
  logic                  miss_q;
  logic [DEG_W-1:0]      deg_q;
  logic [DEG_W-1:0]      cnt_q;
  logic [LINE_W-1:0]     acc_q;

  logic                  out_valid_q;
  logic [LINE_OUT_W-1:0] out_addr_q;
  logic                  out_last_q;
  logic [LINE_OUT_W-1:0] out_addr_d;
  logic                  out_last_d;

  logic [CLASS_W-1:0]    m_cls;
  logic [STRIDE_W-1:0]   m_str;
  logic                  match;
  logic [STRIDE_W-1:0]   s_val;
  logic [DEG_W-1:0]      deg_val;
  logic [LINE_W-1:0]     cl;
  logic [LINE_W-1:0]     cl_next;
  logic [LINE_W-1:0]     s_ext;
  logic [LINE_W-1:0]     nxt;
  logic                  acc_in_page;
  logic                  nxt_in_page;
  logic                  stride_nz;
  logic                  stride_ok;
  logic                  class_nl;
  logic                  stride_last;
  logic                  class_exists;

  always_comb begin
    m_cls = meta_q[META_CLASS_LSB +: CLASS_W];
    m_str = meta_q[STRIDE_W-1:0];
    ent   = written_q[idx_q] ? rd_q : '0;
    match = (ent.tag == tag_q);
    upd   = ent;
    if (!match && !valid_q[idx_q]) begin
      upd.tag    = tag_q;
      upd.cls    = m_cls;
      upd.stride = m_str;
    end
    if (is_pf_q) begin
      upd.cls    = m_cls;
      upd.stride = m_str;
    end
    if (upd.stride[STRIDE_W-1]) begin
      s_val = STRIDE_W'(0) - {1'b0, upd.stride[STRIDE_W-2:0]};
    end else begin
      s_val = {1'b0, upd.stride[STRIDE_W-2:0]};
    end
    if (multi_q) begin
      deg_val = DEGREE_MULTI;
    end else if (upd.cls == CLASS_GLOBAL_STRIDE || below_q) begin
      deg_val = DEGREE_HIGH;
    end else begin
      deg_val = DEGREE_LOW;
    end
  end

  assign cl          = addr_q[ADDR_W-1:BLOCK_OFFSET_BITS];
  assign cl_next     = cl + LINE_W'(1);
  assign s_ext       = {{(LINE_W-STRIDE_W){s_q[STRIDE_W-1]}}, s_q};
  assign nxt         = acc_q + s_ext;
  assign acc_in_page = (acc_q[LINE_W-1:PAGE_LSB] == addr_q[ADDR_W-1:PAGE_OFFSET_BITS]);
  assign nxt_in_page = (nxt[LINE_W-1:PAGE_LSB] == addr_q[ADDR_W-1:PAGE_OFFSET_BITS]);
  assign stride_nz   = (s_q != '0);
  assign stride_ok   = stride_nz &&
                       (cls_q == CLASS_GLOBAL_STRIDE || cls_q == CLASS_CONSTANT_STRIDE);
  assign class_nl    = stride_nz && (cls_q == CLASS_NEXT_LINE) && nle_q;
  assign stride_last = (cnt_q == deg_q) || !nxt_in_page;
  assign class_exists = (stride_ok && acc_in_page) || class_nl;

  always_comb begin
    out_addr_d = LINE_OUT_W'(cl_next);
    out_last_d = 1'b1;
    case (cmd_i.load)
      LD_MISS_NL: begin
        out_addr_d = LINE_OUT_W'(cl_next);
        out_last_d = !class_exists;
      end
      LD_STRIDE: begin
        out_addr_d = LINE_OUT_W'(acc_q);
        out_last_d = stride_last;
      end
      LD_CLASS_NL: begin
        out_addr_d = LINE_OUT_W'(cl_next);
        out_last_d = 1'b1;
      end
      default: begin
        out_addr_d = out_addr_q;
        out_last_d = out_last_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= mem_q[instr_pointer_i[INDEX_BITS-1:0]];
    end
    if (cmd_i.lookup) begin
      mem_q[idx_q] <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q  <= access_address_i;
      idx_q   <= instr_pointer_i[INDEX_BITS-1:0];
      tag_q   <= instr_pointer_i[INDEX_BITS +: TAG_BITS];
      is_pf_q <= is_prefetch_i;
      meta_q  <= metadata_i;
      below_q <= mshr_below_half_i;
    end
    if (cmd_i.lookup) begin
      cls_q  <= upd.cls;
      s_q    <= s_val;
      miss_q <= !match;
      deg_q  <= deg_val;
    end
    if (cmd_i.prep) begin
      acc_q <= cl + s_ext;
    end else if (cmd_i.load == LD_STRIDE) begin
      acc_q <= nxt;
    end
    if (cmd_i.load != LD_NONE) begin
      out_addr_q <= out_addr_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q   <= '0;
      valid_q     <= '0;
      multi_q     <= 1'b0;
      nle_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        multi_q <= cfg_wdata_i;
      end
      if (cmd_i.lookup) begin
        written_q[idx_q] <= 1'b1;
        valid_q[idx_q]   <= match;
        if (is_pf_q) begin
          nle_q <= meta_q[META_NL_BIT];
        end
      end
      if (cmd_i.prep) begin
        cnt_q <= DEG_W'(1);
      end else if (cmd_i.load == LD_STRIDE) begin
        cnt_q <= cnt_q + DEG_W'(1);
      end
      if (cmd_i.load != LD_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.miss         = miss_q;
  assign status_o.stride_first = stride_ok && acc_in_page;
  assign status_o.class_nl     = class_nl;
  assign status_o.stride_last  = stride_last;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o             = out_valid_q;
  assign prefetch_line_address_o = out_addr_q;
  assign last_o                  = out_last_q;

endmodule

// ----- rtl/ipcl2_ctrl.sv -----
// ----------------------------------------------------------------------------
// IP classifier L2 prefetcher controller
// Sequences table lookup, entry update, address preparation and the issue of
// prefetch requests into the output register.
// ----------------------------------------------------------------------------
module ipcl2_ctrl
  import ipcl2_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q;
  ctrl_state_e state_d;
  ctrl_state_e dispatch;

  always_comb begin
    if (status_i.stride_first) begin
      dispatch = ST_STRIDE;
    end else if (status_i.class_nl) begin
      dispatch = ST_CLASS_NL;
    end else begin
      dispatch = ST_IDLE;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = ST_MISS;
      end
      ST_MISS: begin
        if (!status_i.miss || status_i.out_free) begin
          state_d = dispatch;
        end
      end
      ST_STRIDE: begin
        if (status_i.out_free && status_i.stride_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLASS_NL: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.lookup  = 1'b0;
    cmd_o.prep    = 1'b0;
    cmd_o.load    = LD_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      ST_MISS: begin
        if (status_i.miss && status_i.out_free) begin
          cmd_o.load = LD_MISS_NL;
        end
      end
      ST_STRIDE: begin
        if (status_i.out_free) begin
          cmd_o.load = LD_STRIDE;
        end
      end
      ST_CLASS_NL: begin
        if (status_i.out_free) begin
          cmd_o.load = LD_CLASS_NL;
        end
      end
      default: begin
        cmd_o.load = LD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/ip_classifier_l2_prefetcher_unit.sv -----
// ----------------------------------------------------------------------------
// IP classifier L2 prefetcher
// Top level joining the controller and the datapath to the access and
// prefetch channels and the multi-core configuration register.
// ----------------------------------------------------------------------------
// An access request is taken only while the block is idle, and the edge that
// accepts it also reads the table. The next cycle compares the tag and writes
// the entry back, and the one after that prepares the first stride address.
// Then a miss loads its next-line request into the output register, and the
// stride or class next-line requests follow it there one at a time. A
// request that is due while the output register is still full waits until it
// drains. The last issued request may still wait in the output register while
// the next access is taken. The table reads as all zero after reset through
// per-entry written bits, with no clearing pass.
module ip_classifier_l2_prefetcher_unit
  import ipcl2_pkg::*;
#(
  parameter int unsigned INDEX_BITS        = INDEX_BITS_DEF,
  parameter int unsigned TAG_BITS          = TAG_BITS_DEF,
  parameter int unsigned BLOCK_OFFSET_BITS = BLOCK_OFFSET_BITS_DEF,
  parameter int unsigned PAGE_OFFSET_BITS  = PAGE_OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  ipcl2_access_if.sink     access_i,
  ipcl2_prefetch_if.source prefetch_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ipcl2_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (access_i.valid),
    .in_ready_o (access_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ipcl2_datapath #(
    .INDEX_BITS        (INDEX_BITS),
    .TAG_BITS          (TAG_BITS),
    .BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS),
    .PAGE_OFFSET_BITS  (PAGE_OFFSET_BITS)
  ) u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .access_address_i        (access_i.access_address),
    .instr_pointer_i         (access_i.instr_pointer),
    .is_prefetch_i           (access_i.is_prefetch),
    .metadata_i              (access_i.metadata),
    .mshr_below_half_i       (access_i.mshr_below_half),
    .cmd_i                   (cmd),
    .status_o                (status),
    .out_valid_o             (prefetch_o.valid),
    .out_ready_i             (prefetch_o.ready),
    .prefetch_line_address_o (prefetch_o.prefetch_line_address),
    .last_o                  (prefetch_o.last)
  );

  a_load_only_when_free : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (cmd.load != LD_NONE) |-> status.out_free
  ) else $error("Output register loaded while a request is still pending.");

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (access_i.valid && access_i.ready) |=> !access_i.ready
  ) else $error("Access accepted again in the cycle after an acceptance.");

  a_no_issue_when_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni) access_i.ready |-> (cmd.load == LD_NONE)
  ) else $error("Prefetch issued while the controller is idle.");

endmodule
